/* rtl/m3i_pkg.sv */
// Shared constants, payload types and pipeline control type for the 3x3 inverse.
// Depends on nothing; every other file takes names from here by scope.
package m3i_pkg;
   localparam int FRAC_BITS = 16;
   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int COF_W     = PROD_W;
   localparam int DET_W     = ELEM_W + COF_W + 2;
   localparam int DMAG_W    = DET_W - 1;
   localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
   localparam int Q_BITS    = ELEM_W;
   localparam int REM_W     = (NUM_W > DMAG_W + Q_BITS) ? NUM_W : DMAG_W + Q_BITS;
   localparam int N_ELEM    = 9;
   localparam int DET_STAGE = 4;
   localparam int DIV_FIRST = 5;
   localparam int DEPTH     = DIV_FIRST + Q_BITS + 2;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic signed [DET_W-1:0]  det_type;
   typedef logic [3:0]               idx_type;

   // cofactor n = a[i0]*a[i1] - a[i2]*a[i3], sign already folded in
   localparam idx_type COF_IDX [N_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef struct packed {
      elem_type a00; elem_type a01; elem_type a02;
      elem_type a10; elem_type a11; elem_type a12;
      elem_type a20; elem_type a21; elem_type a22;
   } req_type;

   typedef struct packed {
      elem_type r00; elem_type r01; elem_type r02;
      elem_type r10; elem_type r11; elem_type r12;
      elem_type r20; elem_type r21; elem_type r22;
      logic     singular;
      logic     saturated;
   } rsp_type;

   typedef struct packed {
      logic [DEPTH-1:0] en;
   } pipe_ctl_type;
endpackage

/* rtl/m3i_stream_if.sv */
// Valid/ready channel interfaces for matrix requests and inverse responses.
// Depends on m3i_pkg for the payload types.
interface m3i_req_if;
   logic             valid;
   logic             ready;
   m3i_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface m3i_rsp_if;
   logic             valid;
   logic             ready;
   m3i_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/m3i_cofactor.sv */
// Cofactor stages: eighteen 32x32 products, then nine signed differences.
// Depends on m3i_pkg.
module m3i_cofactor (
   input  logic                   clock,
   input  m3i_pkg::pipe_ctl_type  ctl,
   input  m3i_pkg::elem_type      a [m3i_pkg::N_ELEM],
   output m3i_pkg::cof_type       cof [m3i_pkg::N_ELEM],
   output m3i_pkg::elem_type      row0 [3]
);
   logic signed [m3i_pkg::PROD_W-1:0] prod_ff [2*m3i_pkg::N_ELEM];
   m3i_pkg::elem_type                 a_ff [3];
   m3i_pkg::cof_type                  cof_ff [m3i_pkg::N_ELEM];
   m3i_pkg::elem_type                 row0_ff [3];

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         for (int n = 0; n < m3i_pkg::N_ELEM; n++) begin
            prod_ff[2*n]   <= m3i_pkg::PROD_W'(a[m3i_pkg::COF_IDX[n][0]])
                            * m3i_pkg::PROD_W'(a[m3i_pkg::COF_IDX[n][1]]);
            prod_ff[2*n+1] <= m3i_pkg::PROD_W'(a[m3i_pkg::COF_IDX[n][2]])
                            * m3i_pkg::PROD_W'(a[m3i_pkg::COF_IDX[n][3]]);
         end
         for (int j = 0; j < 3; j++) a_ff[j] <= a[j];
      end
      if (ctl.en[1]) begin
         for (int n = 0; n < m3i_pkg::N_ELEM; n++) begin
            cof_ff[n] <= prod_ff[2*n] - prod_ff[2*n+1];
         end
         for (int j = 0; j < 3; j++) row0_ff[j] <= a_ff[j];
      end
   end

   assign cof  = cof_ff;
   assign row0 = row0_ff;
endmodule

/* rtl/m3i_det.sv */
// Determinant stages: split 32x64 products, term assembly, sum and zero check.
// Depends on m3i_pkg; delays the cofactors alongside.
module m3i_det (
   input  logic                   clock,
   input  m3i_pkg::pipe_ctl_type  ctl,
   input  m3i_pkg::cof_type       cof [m3i_pkg::N_ELEM],
   input  m3i_pkg::elem_type      row0 [3],
   output m3i_pkg::cof_type       cof_dly [m3i_pkg::N_ELEM],
   output m3i_pkg::det_type       det,
   output logic                   singular
);
   logic signed [2*m3i_pkg::ELEM_W:0]   lo_ff [3];
   logic signed [m3i_pkg::PROD_W-1:0]   hi_ff [3];
   m3i_pkg::det_type                    term_ff [3];
   m3i_pkg::det_type                    det_ff;
   m3i_pkg::det_type                    sum;
   logic                                sing_ff;
   m3i_pkg::cof_type                    c2_ff [m3i_pkg::N_ELEM];
   m3i_pkg::cof_type                    c3_ff [m3i_pkg::N_ELEM];
   m3i_pkg::cof_type                    c4_ff [m3i_pkg::N_ELEM];

   assign sum = term_ff[0] + term_ff[1] + term_ff[2];

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         for (int j = 0; j < 3; j++) begin
            // low half of the cofactor is unsigned: product needs 65 bits
            lo_ff[j] <= (2*m3i_pkg::ELEM_W+1)'(row0[j])
                      * (2*m3i_pkg::ELEM_W+1)'($signed({1'b0,
                                                cof[j][m3i_pkg::ELEM_W-1:0]}));
            hi_ff[j] <= m3i_pkg::PROD_W'(row0[j])
                      * m3i_pkg::PROD_W'($signed(cof[j][m3i_pkg::COF_W-1:m3i_pkg::ELEM_W]));
         end
         c2_ff <= cof;
      end
      if (ctl.en[3]) begin
         for (int j = 0; j < 3; j++) begin
            term_ff[j] <= (m3i_pkg::DET_W'(hi_ff[j]) <<< m3i_pkg::ELEM_W)
                        + m3i_pkg::DET_W'(lo_ff[j]);
         end
         c3_ff <= c2_ff;
      end
      if (ctl.en[m3i_pkg::DET_STAGE]) begin
         // zero determinant: substitute 1.0 at triple fraction scale
         sing_ff <= (sum == '0);
         det_ff  <= (sum == '0) ? (m3i_pkg::DET_W'(1) <<< (3*m3i_pkg::FRAC_BITS)) : sum;
         c4_ff   <= c3_ff;
      end
   end

   assign cof_dly  = c4_ff;
   assign det      = det_ff;
   assign singular = sing_ff;
endmodule

/* rtl/m3i_div_lane.sv */
// One divider lane: magnitude setup, one restoring quotient bit per stage, saturate.
// Depends on m3i_pkg.
module m3i_div_lane (
   input  logic                   clock,
   input  m3i_pkg::pipe_ctl_type  ctl,
   input  m3i_pkg::cof_type       cof,
   input  m3i_pkg::det_type       det,
   output m3i_pkg::elem_type      quo,
   output logic                   sat
);
   localparam int NS = m3i_pkg::Q_BITS + 1;

   logic [m3i_pkg::REM_W-1:0]  rem_ff  [NS];
   logic [m3i_pkg::DMAG_W-1:0] dsor_ff [NS];
   logic [m3i_pkg::Q_BITS-1:0] q_ff    [NS];
   logic                       neg_ff  [NS];
   logic                       high_ff [NS];
   m3i_pkg::elem_type          quo_ff;
   logic                       sat_ff;

   logic [m3i_pkg::COF_W-1:0]  cmag;
   logic [m3i_pkg::DET_W-1:0]  dabs;
   logic [m3i_pkg::REM_W-1:0]  num;
   logic [m3i_pkg::REM_W:0]    lim;

   always_comb begin
      cmag = cof[m3i_pkg::COF_W-1] ? m3i_pkg::COF_W'(-cof) : m3i_pkg::COF_W'(cof);
      dabs = det[m3i_pkg::DET_W-1] ? m3i_pkg::DET_W'(-det) : m3i_pkg::DET_W'(det);
      num  = m3i_pkg::REM_W'({cmag, {(2*m3i_pkg::FRAC_BITS){1'b0}}});
      lim  = (m3i_pkg::REM_W+1)'(dabs[m3i_pkg::DMAG_W-1:0]) << m3i_pkg::Q_BITS;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[m3i_pkg::DIV_FIRST]) begin
         rem_ff[0]  <= num;
         dsor_ff[0] <= dabs[m3i_pkg::DMAG_W-1:0];
         q_ff[0]    <= '0;
         neg_ff[0]  <= cof[m3i_pkg::COF_W-1] ^ det[m3i_pkg::DET_W-1];
         high_ff[0] <= ({1'b0, num} >= lim);
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_bit
      localparam int B = m3i_pkg::Q_BITS - s;
      logic [m3i_pkg::REM_W:0] trial;
      logic                    take;
      assign trial = (m3i_pkg::REM_W+1)'(dsor_ff[s-1]) << B;
      assign take  = ({1'b0, rem_ff[s-1]} >= trial);
      always_ff @(posedge clock) begin
         if (ctl.en[m3i_pkg::DIV_FIRST+s]) begin
            rem_ff[s]  <= take ? m3i_pkg::REM_W'({1'b0, rem_ff[s-1]} - trial) : rem_ff[s-1];
            q_ff[s]    <= q_ff[s-1] | (take ? (m3i_pkg::Q_BITS'(1) << B) : '0);
            dsor_ff[s] <= dsor_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            high_ff[s] <= high_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[m3i_pkg::DEPTH-1]) begin
         if (neg_ff[NS-1]) begin
            if (high_ff[NS-1] || q_ff[NS-1] > {1'b1, {(m3i_pkg::Q_BITS-1){1'b0}}}) begin
               quo_ff <= {1'b1, {(m3i_pkg::Q_BITS-1){1'b0}}};
               sat_ff <= 1'b1;
            end else begin
               quo_ff <= -$signed(q_ff[NS-1]);
               sat_ff <= 1'b0;
            end
         end else begin
            if (high_ff[NS-1] || q_ff[NS-1][m3i_pkg::Q_BITS-1]) begin
               quo_ff <= {1'b0, {(m3i_pkg::Q_BITS-1){1'b1}}};
               sat_ff <= 1'b1;
            end else begin
               quo_ff <= $signed(q_ff[NS-1]);
               sat_ff <= 1'b0;
            end
         end
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;
endmodule

/* rtl/matrix3_inverse_top.sv */
// 3x3 inverse of a signed Q16.16 matrix: adjugate over exact determinant.
// Pipeline: 39 register stages from the accepted request to the response.
// Throughput: one request per cycle unless the output stalls; the 32 restoring
// quotient stages in each of nine lanes are fully pipelined; bubbles are squeezed out.
// Reset (synchronous, active high) clears only the stage valid bits.
module matrix3_inverse_top (
   input logic        clock,
   input logic        reset,
   m3i_req_if.sink    req_bus,
   m3i_rsp_if.source  rsp_bus
);
   m3i_pkg::pipe_ctl_type          ctl;
   logic [m3i_pkg::DEPTH-1:0]      valid_ff;
   logic [m3i_pkg::DEPTH-1:0]      valid_in;
   logic                           sing_ff [m3i_pkg::DEPTH-m3i_pkg::DIV_FIRST];

   m3i_pkg::elem_type              a [m3i_pkg::N_ELEM];
   m3i_pkg::cof_type               cof [m3i_pkg::N_ELEM];
   m3i_pkg::cof_type               cof_dly [m3i_pkg::N_ELEM];
   m3i_pkg::elem_type              row0 [3];
   m3i_pkg::det_type               det;
   logic                           det_sing;
   m3i_pkg::elem_type              quo [m3i_pkg::N_ELEM];
   logic [m3i_pkg::N_ELEM-1:0]     sat;

   // stage k advances when empty or when the stage after it advances
   always_comb begin
      ctl.en[m3i_pkg::DEPTH-1] = !valid_ff[m3i_pkg::DEPTH-1] || rsp_bus.ready;
      for (int k = m3i_pkg::DEPTH-2; k >= 0; k--) begin
         ctl.en[k] = !valid_ff[k] || ctl.en[k+1];
      end
      valid_in[0] = req_bus.valid;
      for (int k = 1; k < m3i_pkg::DEPTH; k++) valid_in[k] = valid_ff[k-1];
   end

   assign req_bus.ready = ctl.en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < m3i_pkg::DEPTH; k++) begin
            if (ctl.en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   // carry the singular flag from the determinant stage to the output
   always_ff @(posedge clock) begin
      if (ctl.en[m3i_pkg::DIV_FIRST]) sing_ff[0] <= det_sing;
      for (int k = 1; k < m3i_pkg::DEPTH - m3i_pkg::DIV_FIRST; k++) begin
         if (ctl.en[m3i_pkg::DIV_FIRST + k]) sing_ff[k] <= sing_ff[k-1];
      end
   end

   // unpack the request in row-major order
   assign a[0] = req_bus.payload.a00;
   assign a[1] = req_bus.payload.a01;
   assign a[2] = req_bus.payload.a02;
   assign a[3] = req_bus.payload.a10;
   assign a[4] = req_bus.payload.a11;
   assign a[5] = req_bus.payload.a12;
   assign a[6] = req_bus.payload.a20;
   assign a[7] = req_bus.payload.a21;
   assign a[8] = req_bus.payload.a22;

   m3i_cofactor u_cofactor (
      .clock (clock),
      .ctl   (ctl),
      .a     (a),
      .cof   (cof),
      .row0  (row0)
   );

   m3i_det u_det (
      .clock    (clock),
      .ctl      (ctl),
      .cof      (cof),
      .row0     (row0),
      .cof_dly  (cof_dly),
      .det      (det),
      .singular (det_sing)
   );

   // lane for result (i,j) divides the transposed cofactor (j,i)
   for (genvar n = 0; n < m3i_pkg::N_ELEM; n++) begin : g_lane
      m3i_div_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .cof   (cof_dly[(n % 3) * 3 + (n / 3)]),
         .det   (det),
         .quo   (quo[n]),
         .sat   (sat[n])
      );
   end

   // merge lane results into the response
   assign rsp_bus.valid             = valid_ff[m3i_pkg::DEPTH-1];
   assign rsp_bus.payload.r00       = quo[0];
   assign rsp_bus.payload.r01       = quo[1];
   assign rsp_bus.payload.r02       = quo[2];
   assign rsp_bus.payload.r10       = quo[3];
   assign rsp_bus.payload.r11       = quo[4];
   assign rsp_bus.payload.r12       = quo[5];
   assign rsp_bus.payload.r20       = quo[6];
   assign rsp_bus.payload.r21       = quo[7];
   assign rsp_bus.payload.r22       = quo[8];
   assign rsp_bus.payload.singular  = sing_ff[m3i_pkg::DEPTH-m3i_pkg::DIV_FIRST-1];
   assign rsp_bus.payload.saturated = |sat;
endmodule
